/* hw/rtl/rdf_pkg.sv */
// Shared types, constants and a speed digit helper for the ride display digit formatter.
`default_nettype none

package rdf_pkg;

	// View modes, also shown on the result tuser.
	localparam logic [1:0] VIEW_SPEED    = 2'd0;
	localparam logic [1:0] VIEW_DISTANCE = 2'd1;
	localparam logic [1:0] VIEW_TIME     = 2'd2;

	// Configuration register indexes.
	localparam int CFG_ADDR_W = 1;
	localparam int CFG_DATA_W = 1;
	localparam logic [CFG_ADDR_W-1:0] CFG_METRIC_UNITS   = 1'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_DISPLAY_ENABLE = 1'd1;

	// Field widths.
	localparam int SPEED_W = 14;
	localparam int DIST_W  = 20;
	localparam int SECS_W  = 16;
	localparam int DIGIT_W = 4;
	localparam int MODE_W  = 2;

	localparam int IN_DATA_W  = 4 * SPEED_W + 2 * DIST_W + SECS_W;
	localparam int OUT_BITS   = 4 * DIGIT_W + 3;
	localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

	// Saturation thresholds, in input units.
	localparam int SPEED_SAT = 1000;
	localparam int DIST_SAT  = 10000;
	localparam int TIME_SAT  = 6000;

	typedef struct packed {
		logic [DIGIT_W-1:0] hi;
		logic [DIGIT_W-1:0] lo;
		logic               pt;
	} speed_pair_t;

	typedef struct packed {
		logic [DIGIT_W-1:0] d0;
		logic [DIGIT_W-1:0] d1;
		logic [DIGIT_W-1:0] d2;
		logic [DIGIT_W-1:0] d3;
		logic               p0;
		logic               p1;
		logic               p2;
		logic [MODE_W-1:0]  mode;
	} result_t;

	// Split one speed in tenths into two digits: d.d below 10, dd below 100, else 99.
	function automatic speed_pair_t put_speed(input logic [SPEED_W-1:0] v);
		speed_pair_t r;
		logic [9:0]  v10;
		logic [23:0] p100;
		logic [21:0] p10;
		logic [3:0]  q100;
		logic [6:0]  q10;
		logic [6:0]  rem100;
		logic [9:0]  rem10;
		v10    = v[9:0];
		p100   = 24'(v10) * 24'd5243;
		p10    = 22'(v10) * 22'd205;
		q100   = p100[22:19];
		q10    = p10[17:11];
		rem100 = q10 - 7'(q100) * 7'd10;
		rem10  = v10 - 10'(q10) * 10'd10;
		if (v >= SPEED_W'(SPEED_SAT)) begin
			r.hi = 4'd9;
			r.lo = 4'd9;
			r.pt = 1'b0;
		end else if (v10 >= 10'd100) begin
			r.hi = q100;
			r.lo = rem100[3:0];
			r.pt = 1'b0;
		end else begin
			r.hi = q10[3:0];
			r.lo = rem10[3:0];
			r.pt = 1'b1;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/ride_display_digit_formatter_top.sv */
// An accepted beat passes the input register, then the result register that drives m_axis.
// Throughput: one beat per cycle; the input register and the result register
// each advance when the next stage is empty or its beat is being taken.
// A refresh beat while the display is disabled produces no result.
// Reset (arst_n low, asynchronous): speed view, mile units, display disabled, pipeline empty.
`default_nettype none

module ride_display_digit_formatter_top import rdf_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic                  s_axis_tvalid,
	output      logic                  s_axis_tready,
	// bits from 0: cur_speed_imperial, cur_speed_metric, avg_speed_imperial,
	// avg_speed_metric, distance_imperial, distance_metric, elapsed_seconds
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
	// bit 0: command
	input  wire logic                  s_axis_tuser,
	output      logic                  m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	// bits from 0: digit_zero, digit_one, digit_two, digit_three,
	// point_zero, point_one, point_two, zero fill
	output      logic [OUT_DATA_W-1:0] m_axis_tdata,
	// bits from 0: shown_mode
	output      logic [MODE_W-1:0]     m_axis_tuser
);

	logic               metric_units_q;
	logic               display_enable_q;
	logic [MODE_W-1:0]  view_mode_q;
	logic [MODE_W-1:0]  view_next;

	logic               valid_s1;
	logic [MODE_W-1:0]  mode_s1;
	logic [SPEED_W-1:0] cur_speed_s1;
	logic [SPEED_W-1:0] avg_speed_s1;
	logic [DIST_W-1:0]  distance_s1;
	logic [SECS_W-1:0]  secs_s1;

	logic               out_valid_q;
	result_t            result_q;
	result_t            result_d;

	logic               accept;
	logic               adv_out;

	logic [SPEED_W-1:0] in_cs_imp;
	logic [SPEED_W-1:0] in_cs_met;
	logic [SPEED_W-1:0] in_as_imp;
	logic [SPEED_W-1:0] in_as_met;
	logic [DIST_W-1:0]  in_dist_imp;
	logic [DIST_W-1:0]  in_dist_met;
	logic [SECS_W-1:0]  in_secs;

	assign {in_secs, in_dist_met, in_dist_imp, in_as_met, in_as_imp, in_cs_met, in_cs_imp}
		= s_axis_tdata;

	assign adv_out       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || adv_out;
	assign accept        = s_axis_tvalid && s_axis_tready;

	always_comb begin
		view_next = view_mode_q;
		if (s_axis_tuser) begin
			view_next = (view_mode_q == VIEW_TIME) ? VIEW_SPEED : view_mode_q + 2'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			metric_units_q   <= 1'b0;
			display_enable_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_METRIC_UNITS:   metric_units_q   <= cfg_wdata[0];
				CFG_DISPLAY_ENABLE: display_enable_q <= cfg_wdata[0];
				default:            metric_units_q   <= metric_units_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			view_mode_q <= VIEW_SPEED;
			valid_s1    <= 1'b0;
		end else begin
			if (accept) begin
				view_mode_q <= view_next;
			end
			if (s_axis_tready) begin
				// drop refresh beats while the display is off
				valid_s1 <= accept && (s_axis_tuser || display_enable_q);
			end
		end
	end

	// Pick the unit set on entry so the next stage sees one value per quantity.
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1      <= view_next;
			cur_speed_s1 <= metric_units_q ? in_cs_met : in_cs_imp;
			avg_speed_s1 <= metric_units_q ? in_as_met : in_as_imp;
			distance_s1  <= metric_units_q ? in_dist_met : in_dist_imp;
			secs_s1      <= in_secs;
		end
	end

	rdf_format u_format (
		.mode            (mode_s1),
		.cur_speed       (cur_speed_s1),
		.avg_speed       (avg_speed_s1),
		.distance        (distance_s1),
		.elapsed_seconds (secs_s1),
		.result          (result_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_out) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out && valid_s1) begin
			result_q <= result_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {(OUT_DATA_W - OUT_BITS)'(0),
		result_q.p2, result_q.p1, result_q.p0,
		result_q.d3, result_q.d2, result_q.d1, result_q.d0};
	assign m_axis_tuser  = result_q.mode;

	a_stage_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv_out) |=> m_axis_tvalid)
		else $error("occupied input stage did not reach the result register");

	a_refresh_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !s_axis_tuser && !display_enable_q) |=> !valid_s1)
		else $error("refresh beat passed while display disabled");

	a_toggle_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_axis_tuser) |=> (view_mode_q != $past(view_mode_q)))
		else $error("toggle beat did not advance the view");

	a_distance_point: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser == VIEW_DISTANCE) |->
		(result_q.p2 && !result_q.p1 && !result_q.p0))
		else $error("distance view with wrong decimal points");

endmodule

`default_nettype wire

/* hw/rtl/rdf_format.sv */
// Combinational digit splitter: turns the selected ride values into display digits.
`default_nettype none

module rdf_format import rdf_pkg::*; (
	input  wire logic [MODE_W-1:0]  mode,
	input  wire logic [SPEED_W-1:0] cur_speed,
	input  wire logic [SPEED_W-1:0] avg_speed,
	input  wire logic [DIST_W-1:0]  distance,
	input  wire logic [SECS_W-1:0]  elapsed_seconds,
	output result_t                 result
);

	speed_pair_t cur_pair;
	speed_pair_t avg_pair;

	// distance pieces, valid below saturation
	logic [13:0] x14;
	logic [31:0] dp1000;
	logic [31:0] dp100;
	logic [31:0] dp10;
	logic [3:0]  dq1000;
	logic [6:0]  dq100;
	logic [9:0]  dq10;
	logic [6:0]  dr1;
	logic [9:0]  dr2;
	logic [13:0] dr3;

	// time pieces, valid below saturation
	logic [12:0] s13;
	logic [31:0] tp_min;
	logic [31:0] tp_ten;
	logic [6:0]  mins;
	logic [3:0]  min_tens;
	logic [6:0]  min_ones;
	logic [12:0] sec_full;
	logic [5:0]  sec;
	logic [10:0] sp;
	logic [3:0]  sec_tens;
	logic [5:0]  sec_ones;

	always_comb begin
		cur_pair = put_speed(cur_speed);
		avg_pair = put_speed(avg_speed);
	end

	// Reciprocal multiplies, each taken straight from the value to keep the paths short.
	always_comb begin
		x14    = distance[13:0];
		dp1000 = 32'(x14) * 32'd16778;
		dp100  = 32'(x14) * 32'd5243;
		dp10   = 32'(x14) * 32'd52429;
		dq1000 = dp1000[27:24];
		dq100  = dp100[25:19];
		dq10   = dp10[28:19];
		dr1    = dq100 - 7'(dq1000) * 7'd10;
		dr2    = dq10 - 10'(dq100) * 10'd10;
		dr3    = x14 - 14'(dq10) * 14'd10;
	end

	always_comb begin
		s13      = elapsed_seconds[12:0];
		tp_min   = 32'(s13) * 32'd34953;
		tp_ten   = 32'(s13) * 32'd13982;
		mins     = tp_min[27:21];
		min_tens = tp_ten[26:23];
		min_ones = mins - 7'(min_tens) * 7'd10;
		sec_full = s13 - 13'(mins) * 13'd60;
		sec      = sec_full[5:0];
		sp       = 11'(sec) * 11'd13;
		sec_tens = sp[10:7];
		sec_ones = sec - 6'(sec_tens) * 6'd10;
	end

	always_comb begin
		result      = '0;
		result.mode = mode;
		unique case (mode)
			VIEW_SPEED: begin
				result.d0 = cur_pair.hi;
				result.d1 = cur_pair.lo;
				result.p0 = cur_pair.pt;
				result.d2 = avg_pair.hi;
				result.d3 = avg_pair.lo;
				result.p2 = avg_pair.pt;
			end
			VIEW_DISTANCE: begin
				result.p2 = 1'b1;
				if (distance >= DIST_W'(DIST_SAT)) begin
					result.d0 = 4'd9;
					result.d1 = 4'd9;
					result.d2 = 4'd9;
					result.d3 = 4'd9;
				end else begin
					result.d0 = dq1000;
					result.d1 = dr1[3:0];
					result.d2 = dr2[3:0];
					result.d3 = dr3[3:0];
				end
			end
			VIEW_TIME: begin
				result.p1 = 1'b1;
				if (elapsed_seconds >= SECS_W'(TIME_SAT)) begin
					result.d0 = 4'd9;
					result.d1 = 4'd9;
					result.d2 = 4'd5;
					result.d3 = 4'd9;
				end else begin
					result.d0 = min_tens;
					result.d1 = min_ones[3:0];
					result.d2 = sec_tens;
					result.d3 = sec_ones[3:0];
				end
			end
			default: begin
				result.mode = mode;
			end
		endcase
	end

endmodule

`default_nettype wire
